// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL, clocked on clk with asynchronous reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define SCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SCM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SCM_ASSERT(lbl, prop, msg)
`define SCM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/scm_pkg.sv =====
// Types and constants of the superset count multiset.
package scm_pkg;

	localparam int VALUE_W = 17;
	localparam int COUNT_W = 20;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_QUERY = 2'd2
	} scm_op_t;

	typedef struct packed {
		scm_op_t              op;
		logic [VALUE_W-1:0]   value;
	} scm_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]   match_count;
	} scm_result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} scm_state_t;

endpackage

// ===== hdl/scm_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface scm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/scm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module scm_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 131072
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/superset_count_multiset.sv =====
// Top level: multiset of keys as a count memory with superset count queries.
//
//  channel  dir  payload                 transfer
//  item     in   op, value               valid && ready
//  result   out  match_count             valid && ready, query only
//
// After reset a clearing pass zeroes all 2**KEY_BITS words of the count memory
// (131072 at KEY_BITS = 17); item.ready stays low meanwhile.
// Add and delete go through accept, memory read and write back.
// A query reads the count of every superset of its key, one count memory read per cycle.
// The result register lets the next item in while a result waits; a query
// that completes while the previous result is still held waits for it to go.
`include "assert_macros.svh"

module superset_count_multiset import scm_pkg::*; #(
	parameter int KEY_BITS = 17
) (
	input  logic         clk,
	input  logic         arst_n,
	scm_stream_if.sink   item,
	scm_stream_if.source result
);

	localparam int DEPTH = 2 ** KEY_BITS;
	localparam logic [KEY_BITS-1:0] KEY_MASK = '1;

	scm_state_t state_q, state_d;

	logic [KEY_BITS-1:0] key_in;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] s_q;
	logic [KEY_BITS-1:0] s_next;
	logic [KEY_BITS-1:0] clr_addr_q;
	logic                is_del_q;
	logic                accept;
	logic                item_ready;
	logic                load_out;
	logic                out_free;
	logic                walk_vld_s1;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  acc_q;
	logic [COUNT_W-1:0]  acc_next;
	logic [COUNT_W:0]    sum_ext;
	logic [COUNT_W-1:0]  out_q;
	logic [COUNT_W-1:0]  upd_data;

	logic                ram_wr_en;
	logic [KEY_BITS-1:0] ram_wr_addr;
	logic [COUNT_W-1:0]  ram_wr_data;
	logic                ram_rd_en;
	logic [KEY_BITS-1:0] ram_rd_addr;
	logic [COUNT_W-1:0]  ram_rd_data;

	scm_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (DEPTH)
	) u_count_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign key_in   = KEY_BITS'(item.payload.value);
	assign accept   = item.valid && item_ready;
	assign out_free = !out_valid_q || result.ready;

	// next superset of the query pattern
	assign s_next = (s_q + KEY_BITS'(1)) | key_q;

	assign sum_ext  = {1'b0, acc_q} + {1'b0, ram_rd_data};
	assign acc_next = sum_ext[COUNT_W] ? COUNT_MAX : sum_ext[COUNT_W-1:0];

	always_comb begin
		if (is_del_q) begin
			upd_data = (ram_rd_data == '0) ? ram_rd_data : ram_rd_data - COUNT_W'(1);
		end else begin
			upd_data = (ram_rd_data == COUNT_MAX) ? ram_rd_data : ram_rd_data + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = key_q;
		ram_wr_data = upd_data;
		ram_rd_en   = 1'b0;
		ram_rd_addr = key_q;
		load_out    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_addr_q;
				ram_wr_data = '0;
				if (clr_addr_q == KEY_MASK) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item.valid) begin
					unique case (item.payload.op) inside
						OP_ADD, OP_DEL: state_d = ST_UPD_RD;
						OP_QUERY:       state_d = ST_WALK;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_UPD_RD: begin
				ram_rd_en = 1'b1;
				state_d   = ST_UPD_WR;
			end
			ST_UPD_WR: begin
				ram_wr_en = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_WALK: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = s_q;
				if (s_q == KEY_MASK) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			walk_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + KEY_BITS'(1);
			end
			walk_vld_s1 <= (state_q == ST_WALK);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= key_in;
			s_q      <= key_in;
			is_del_q <= (item.payload.op == OP_DEL);
			acc_q    <= '0;
		end else begin
			if (state_q == ST_WALK) begin
				s_q <= s_next;
			end
			if (walk_vld_s1) begin
				acc_q <= acc_next;
			end
		end
		if (load_out) begin
			out_q <= acc_q;
		end
	end

	assign item.ready                 = item_ready;
	assign result.valid               = out_valid_q;
	assign result.payload.match_count = out_q;

	`SCM_ASSERT(a_walk_superset, (state_q == ST_WALK) |-> ((s_q & key_q) == key_q), "walk address lost query bits")
	`SCM_ASSERT(a_acc_monotonic, walk_vld_s1 |=> (acc_q >= $past(acc_q)), "query sum decreased")
	`SCM_ASSERT(a_rd_after_walk, walk_vld_s1 |-> ($past(state_q) == ST_WALK), "accumulate without walk read")
	`SCM_ASSERT_ALWAYS(a_no_ready_reset, !arst_n |-> !item.ready, "item ready during reset")

endmodule
